// ----- hdl/node_heartbeat_health_tracker_assert.svh -----
// Assertion macros shared by the heartbeat health tracker RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef NODE_HEARTBEAT_HEALTH_TRACKER_ASSERT_SVH
`define NODE_HEARTBEAT_HEALTH_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NHHT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NHHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/nhht_pkg.sv -----
// Package for the heartbeat health tracker: table geometry, health codes,
// register map and the request, response and configuration types. No dependencies.
package nhht_pkg;

	localparam int NODE_COUNT = 256;
	localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	localparam logic [1:0] ST_HEALTHY = 2'd0;
	localparam logic [1:0] ST_SUSPECT = 2'd1;
	localparam logic [1:0] ST_DEAD    = 2'd2;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam int         PADDR_W     = 3;
	localparam logic       REG_SUSPECT = 1'b0;
	localparam logic       REG_DEAD    = 1'b1;
	localparam logic [7:0] SUSPECT_RESET = 8'd3;
	localparam logic [7:0] DEAD_RESET    = 8'd30;

	localparam logic [7:0] MISS_MAX = 8'hFF;

	typedef struct packed {
		logic       action;
		logic [7:0] node_index;
		logic       alive;
	} req_t;

	typedef struct packed {
		logic [7:0] node_echo;
		logic [1:0] health;
		logic       changed;
		logic [7:0] miss_total;
	} rsp_t;

	typedef struct packed {
		logic [7:0] suspect_threshold;
		logic [7:0] dead_threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0] health;
		logic [7:0] miss;
	} entry_t;

	localparam int     ENTRY_W     = $bits(entry_t);
	localparam entry_t ENTRY_RESET = '{health: ST_HEALTHY, miss: 8'd0};

endpackage

// ----- hdl/nhht_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// A read of the address being written returns the old contents. No dependencies.
module nhht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/nhht_regs.sv -----
// APB register block holding the suspect and dead miss thresholds.
// Depends on nhht_pkg for the register map, reset values and cfg_t.
module nhht_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nhht_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output nhht_pkg::cfg_t               cfg
);
	import nhht_pkg::*;

	logic [7:0] suspect_q;
	logic [7:0] dead_q;
	logic       reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suspect_q <= SUSPECT_RESET;
			dead_q    <= DEAD_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SUSPECT: suspect_q <= pwdata[7:0];
				REG_DEAD:    dead_q    <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SUSPECT: prdata = {24'd0, suspect_q};
			REG_DEAD:    prdata = {24'd0, dead_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg = '{suspect_threshold: suspect_q, dead_threshold: dead_q};

endmodule

// ----- hdl/nhht_engine.sv -----
// Table engine: post-reset clearing pass, read-modify-write of the node table
// with forwarding, and the response register. Depends on nhht_pkg, nhht_ram and the assertion macro header.
`include "node_heartbeat_health_tracker_assert.svh"

module nhht_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  nhht_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_ready,
	input  nhht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nhht_pkg::rsp_t rsp
);
	import nhht_pkg::*;

	logic               clr_active_q;
	logic [NODE_AW-1:0] clr_addr_q;

	logic               valid_s1;
	req_t               req_s1;
	logic               in_range_s1;
	logic [NODE_AW-1:0] addr_s1;

	logic               fwd_valid_q;
	logic [NODE_AW-1:0] fwd_addr_q;
	entry_t             fwd_data_q;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               commit;
	logic               upd_write;
	logic               in_range;
	logic [NODE_AW-1:0] req_addr;

	logic               ram_we;
	logic [NODE_AW-1:0] ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t             cur;
	entry_t             nxt;
	logic [7:0]         miss_inc;
	logic               chg;
	rsp_t               rsp_d;

	assign in_range  = (32'(req.node_index) < 32'(NODE_COUNT));
	assign req_addr  = NODE_AW'(req.node_index);
	assign commit    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_active_q && (!valid_s1 || commit);
	assign accept    = req_valid && req_ready;
	assign upd_write = commit && in_range_s1 && (req_s1.action == ACT_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == NODE_AW'(NODE_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + NODE_AW'(1);
		end
	end

	assign ram_we    = clr_active_q || upd_write;
	assign ram_waddr = clr_active_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_active_q ? ENTRY_RESET : nxt;

	nhht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(req_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			in_range_s1 <= in_range;
			addr_s1     <= req_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (upd_write) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_write) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

	always_comb begin
		cur      = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : entry_t'(ram_rdata);
		nxt      = cur;
		chg      = 1'b0;
		miss_inc = (cur.miss == MISS_MAX) ? cur.miss : cur.miss + 8'd1;
		if (req_s1.action == ACT_UPDATE) begin
			if (req_s1.alive) begin
				nxt.miss = 8'd0;
				if (cur.health != ST_HEALTHY) begin
					nxt.health = ST_HEALTHY;
					chg        = 1'b1;
				end
			end else begin
				nxt.miss = miss_inc;
				if (cur.health == ST_HEALTHY && miss_inc >= cfg.suspect_threshold) begin
					nxt.health = ST_SUSPECT;
					chg        = 1'b1;
				end else if (cur.health == ST_SUSPECT && miss_inc >= cfg.dead_threshold) begin
					nxt.health = ST_DEAD;
					chg        = 1'b1;
				end
			end
		end
		rsp_d.node_echo = req_s1.node_index;
		if (in_range_s1) begin
			rsp_d.health     = nxt.health;
			rsp_d.changed    = chg;
			rsp_d.miss_total = nxt.miss;
		end else begin
			rsp_d.health     = ST_HEALTHY;
			rsp_d.changed    = 1'b0;
			rsp_d.miss_total = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`NHHT_ASSERT(a_no_req_in_clear, clr_active_q, !req_ready, "request taken during clear")
	`NHHT_ASSERT(a_clear_writes_reset, clr_active_q, ram_we && (ram_wdata == ENTRY_RESET),
		"clearing pass wrote a non-reset entry")
	`NHHT_ASSERT(a_read_no_write, valid_s1 && !clr_active_q && (req_s1.action == ACT_READ),
		!ram_we, "read request wrote the table")
	`NHHT_ASSERT_NEXT(a_commit_fills_rsp, commit, rsp_valid_q, "committed request lost")
	`NHHT_ASSERT_NEXT(a_fwd_tracks_write, upd_write,
		fwd_valid_q && (fwd_addr_q == $past(addr_s1)), "forwarding register missed a write")

endmodule

// ----- hdl/node_heartbeat_health_tracker.sv -----
// Heartbeat health tracker, top level: APB thresholds and the table engine.
// Depends on nhht_pkg, nhht_regs and nhht_engine.
//
// Each request is one read-modify-write of a per-node table entry held in a
// single RAM; the last write is forwarded, so a request is accepted every cycle
// while the response is not stalled, and its response is registered in the
// output register. After reset a clearing pass over all NODE_COUNT (256) entries
// writes each back to healthy with zero misses; no request is accepted until it ends.
module node_heartbeat_health_tracker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nhht_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  nhht_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output nhht_pkg::rsp_t               rsp
);
	import nhht_pkg::*;

	cfg_t cfg;

	nhht_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	nhht_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
